// ===== rtl/pctr_pkg.sv =====
// Shared types and constants for the page cache tag directory.
// Used by page_cache_tag_replacement and the testbench; depends on nothing.
`timescale 1ns / 1ps

package pctr_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned LIMIT_W  = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd2;

  typedef enum logic [OP_W-1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_FLUSH   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT    = 3'd0,
    ST_FILLED = 3'd1,
    ST_WMISS  = 3'd2,
    ST_DONE   = 3'd3,
    ST_REJECT = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_e;

endpackage

// ===== rtl/pctr_tag_ram.sv =====
// Simple dual-port tag memory: one write and one registered read per cycle.
// Standalone; holds {pid, page, age} words for the tag directory.
`timescale 1ns / 1ps

module pctr_tag_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 48,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== rtl/page_cache_tag_replacement.sv =====
// Tag directory of a page cache with oldest-age replacement and a per-process quota.
// Depends on pctr_pkg and pctr_tag_ram.
`timescale 1ns / 1ps

// Usage
//   s_axis: one command word per item: opcode, pid, page. s_axis_tready is high
//   only while no command is in flight; a finished result may still sit in the
//   output register while the next command is taken.
//   m_axis: one result word per command: status, slot, replaced entry.
//   cfg: write of per_process_limit, always ready; write it only while idle.
// Timing
//   read, write and release walk the tag memory, one entry per cycle through
//   its single read port: a read of each of the ENTRIES entries, the registered
//   read data, a decision/write-back state and the load of the output register;
//   m_axis_tvalid rises as the block returns to idle, and the next command can
//   be taken from then on.
//   Flush and commands with pid zero need no walk and go straight to the output register.
// Reset
//   all entries empty at once (per-entry occupied flags), limit back to 2.
// Stall
//   if m_axis_tready stays low the result waits in the output register; one
//   more command may be accepted and finishes up to its result, then holds.

module page_cache_tag_replacement #(
  parameter int unsigned ENTRIES   = 16,
  parameter int unsigned PID_BITS  = 16,
  parameter int unsigned PAGE_BITS = 16,
  parameter int unsigned AGE_BITS  = 16,
  localparam int unsigned IN_W  = ((pctr_pkg::OP_W + PID_BITS + PAGE_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((pctr_pkg::STATUS_W + pctr_pkg::SLOT_W + 1
                                    + PID_BITS + PAGE_BITS + 7) / 8) * 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // fields from bit 0 up: opcode, pid, page, zero fill
  input  logic [IN_W-1:0]              s_axis_tdata,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // fields from bit 0 up: status, slot, replaced_valid, replaced_pid, replaced_page
  output logic [OUT_W-1:0]             m_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // per_process_limit
  input  logic [pctr_pkg::LIMIT_W-1:0] cfg_data_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > pctr_pkg::LIMIT_W) ? CNT_W : pctr_pkg::LIMIT_W;
  localparam int unsigned ENT_W = PID_BITS + PAGE_BITS + AGE_BITS;
  localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX  = {AGE_BITS{1'b1}};

  pctr_pkg::state_e state_q, state_d;

  // command being worked on
  pctr_pkg::op_e         op_q;
  logic [PID_BITS-1:0]   pid_q;
  logic [PAGE_BITS-1:0]  page_q;

  logic [pctr_pkg::LIMIT_W-1:0] limit_q;
  logic [ENTRIES-1:0]           valid_q;

  // walk over the memory
  logic [CNT_W-1:0] issue_q;
  logic             dv_q;
  logic [IDX_W-1:0] didx_q;

  // scan results
  logic                 hit_q;
  logic [IDX_W-1:0]     hit_idx_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 own_q;
  logic [IDX_W-1:0]     own_idx_q;
  logic [AGE_BITS-1:0]  own_age_q;
  logic [PAGE_BITS-1:0] own_page_q;
  logic                 free_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic                 any_q;
  logic [IDX_W-1:0]     any_idx_q;
  logic [AGE_BITS-1:0]  any_age_q;
  logic [PID_BITS-1:0]  any_pid_q;
  logic [PAGE_BITS-1:0] any_page_q;

  // pending result
  pctr_pkg::status_e            res_status_q;
  logic [pctr_pkg::SLOT_W-1:0]  res_slot_q;
  logic                         res_rv_q;
  logic [PID_BITS-1:0]          res_rpid_q;
  logic [PAGE_BITS-1:0]         res_rpage_q;

  logic             m_valid_q;
  logic [OUT_W-1:0] m_data_q;

  // input word
  pctr_pkg::op_e        in_op;
  logic [PID_BITS-1:0]  in_pid;
  logic [PAGE_BITS-1:0] in_page;
  logic                 in_fire;

  assign in_op   = pctr_pkg::op_e'(s_axis_tdata[pctr_pkg::OP_W-1:0]);
  assign in_pid  = s_axis_tdata[pctr_pkg::OP_W +: PID_BITS];
  assign in_page = s_axis_tdata[pctr_pkg::OP_W + PID_BITS +: PAGE_BITS];

  assign s_axis_tready = (state_q == pctr_pkg::S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // memory ports
  logic              re, we;
  logic [IDX_W-1:0]  raddr, waddr;
  logic [ENT_W-1:0]  wdata, rdata;

  pctr_tag_ram #(
    .DEPTH (ENTRIES),
    .WIDTH (ENT_W)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign re    = (state_q == pctr_pkg::S_SCAN) && (issue_q < CNT_W'(ENTRIES));
  assign raddr = issue_q[IDX_W-1:0];

  // entry returning from memory; ent_v tells whether it is occupied, its data is not cleared
  logic                 ent_v;
  logic [PID_BITS-1:0]  r_pid;
  logic [PAGE_BITS-1:0] r_page;
  logic [AGE_BITS-1:0]  r_age, r_aged;
  logic                 r_own, r_hit, scan_v;

  assign ent_v  = valid_q[didx_q];
  assign r_age  = rdata[AGE_BITS-1:0];
  assign r_page = rdata[AGE_BITS +: PAGE_BITS];
  assign r_pid  = rdata[AGE_BITS + PAGE_BITS +: PID_BITS];
  assign r_aged = (op_q == pctr_pkg::OP_READ && r_age != AGE_MAX) ? r_age + 1'b1 : r_age;
  assign scan_v = (state_q == pctr_pkg::S_SCAN) && dv_q;
  assign r_own  = ent_v && (r_pid == pid_q);
  assign r_hit  = r_own && (r_page == page_q);

  // replacement choice
  logic             own_sel;
  logic [IDX_W-1:0] victim;

  assign own_sel = own_q && (CMP_W'(cnt_q) >= CMP_W'(limit_q));
  assign victim  = own_sel ? own_idx_q : (free_q ? free_idx_q : any_idx_q);

  always_comb begin
    we    = 1'b0;
    waddr = didx_q;
    wdata = {r_pid, r_page, r_aged};
    if (scan_v && op_q == pctr_pkg::OP_READ && ent_v) begin
      we = 1'b1;
    end else if (state_q == pctr_pkg::S_DECIDE) begin
      wdata = {pid_q, page_q, {AGE_BITS{1'b0}}};
      if (op_q == pctr_pkg::OP_READ && !hit_q) begin
        we    = 1'b1;
        waddr = victim;
      end else if (op_q == pctr_pkg::OP_WRITE && hit_q) begin
        we    = 1'b1;
        waddr = hit_idx_q;
      end
    end
  end

  // state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pctr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pctr_pkg::S_IDLE: begin
        if (in_fire) begin
          if (in_op == pctr_pkg::OP_FLUSH || in_pid == '0) begin
            state_d = pctr_pkg::S_RESP;
          end else begin
            state_d = pctr_pkg::S_SCAN;
          end
        end
      end
      pctr_pkg::S_SCAN: begin
        if (dv_q && didx_q == LAST_IDX) begin
          state_d = pctr_pkg::S_DECIDE;
        end
      end
      pctr_pkg::S_DECIDE: begin
        state_d = pctr_pkg::S_RESP;
      end
      pctr_pkg::S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = pctr_pkg::S_IDLE;
        end
      end
      default: state_d = pctr_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= pctr_pkg::LIMIT_RESET;
      valid_q   <= '0;
      issue_q   <= '0;
      dv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_data_i;
      end

      if (in_fire && in_op == pctr_pkg::OP_FLUSH) begin
        valid_q <= '0;
      end else if (scan_v && op_q == pctr_pkg::OP_RELEASE && r_own) begin
        valid_q[didx_q] <= 1'b0;
      end else if (state_q == pctr_pkg::S_DECIDE && op_q == pctr_pkg::OP_READ && !hit_q) begin
        valid_q[victim] <= 1'b1;
      end

      if (in_fire) begin
        issue_q <= '0;
      end else if (re) begin
        issue_q <= issue_q + 1'b1;
      end
      dv_q <= re;

      if (state_q == pctr_pkg::S_RESP && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    didx_q <= raddr;

    if (in_fire) begin
      op_q    <= in_op;
      pid_q   <= in_pid;
      page_q  <= in_page;
      hit_q   <= 1'b0;
      cnt_q   <= '0;
      own_q   <= 1'b0;
      free_q  <= 1'b0;
      any_q   <= 1'b0;
      res_slot_q  <= '0;
      res_rv_q    <= 1'b0;
      res_rpid_q  <= '0;
      res_rpage_q <= '0;
      if (in_op == pctr_pkg::OP_FLUSH) begin
        res_status_q <= pctr_pkg::ST_DONE;
      end else begin
        res_status_q <= pctr_pkg::ST_REJECT;
      end
    end

    if (scan_v) begin
      if (r_hit && !hit_q) begin
        hit_q     <= 1'b1;
        hit_idx_q <= didx_q;
      end
      if (r_own) begin
        cnt_q <= cnt_q + 1'b1;
        // strict compare keeps the lowest index on equal ages
        if (!own_q || r_aged > own_age_q) begin
          own_q      <= 1'b1;
          own_idx_q  <= didx_q;
          own_age_q  <= r_aged;
          own_page_q <= r_page;
        end
      end
      if (!ent_v && !free_q) begin
        free_q     <= 1'b1;
        free_idx_q <= didx_q;
      end
      if (ent_v && (!any_q || r_aged > any_age_q)) begin
        any_q      <= 1'b1;
        any_idx_q  <= didx_q;
        any_age_q  <= r_aged;
        any_pid_q  <= r_pid;
        any_page_q <= r_page;
      end
    end

    if (state_q == pctr_pkg::S_DECIDE) begin
      res_slot_q  <= '0;
      res_rv_q    <= 1'b0;
      res_rpid_q  <= '0;
      res_rpage_q <= '0;
      case (op_q)
        pctr_pkg::OP_READ: begin
          if (hit_q) begin
            res_status_q <= pctr_pkg::ST_HIT;
            res_slot_q   <= pctr_pkg::SLOT_W'(hit_idx_q);
          end else begin
            res_status_q <= pctr_pkg::ST_FILLED;
            res_slot_q   <= pctr_pkg::SLOT_W'(victim);
            if (own_sel) begin
              res_rv_q    <= 1'b1;
              res_rpid_q  <= pid_q;
              res_rpage_q <= own_page_q;
            end else if (!free_q) begin
              res_rv_q    <= 1'b1;
              res_rpid_q  <= any_pid_q;
              res_rpage_q <= any_page_q;
            end
          end
        end
        pctr_pkg::OP_WRITE: begin
          if (hit_q) begin
            res_status_q <= pctr_pkg::ST_HIT;
            res_slot_q   <= pctr_pkg::SLOT_W'(hit_idx_q);
          end else begin
            res_status_q <= pctr_pkg::ST_WMISS;
          end
        end
        default: res_status_q <= pctr_pkg::ST_DONE;
      endcase
    end

    if (state_q == pctr_pkg::S_RESP && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= OUT_W'({res_rpage_q, res_rpid_q, res_rv_q, res_slot_q, res_status_q});
    end
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench for page_cache_tag_replacement: streams directed and random commands,
// predicts each result word with its own tag directory and checks them in order.
// Depends on pctr_pkg and the RTL of the block; reads nothing else.

module tb;

  localparam int unsigned N_ENTRIES   = 16;
  localparam int unsigned PID_W       = 16;
  localparam int unsigned PAGE_W      = 16;
  localparam int unsigned AGE_W       = 16;
  localparam int unsigned CMD_W       = 40;
  localparam int unsigned RESP_W      = 40;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned PHASE_ITEMS = 175;
  localparam int unsigned N_PHASES    = 8;

  typedef struct {
    pctr_pkg::op_e     op;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] page;
    bit                drain;
  } dir_cmd_t;

  typedef struct {
    pctr_pkg::status_e           status;
    logic [pctr_pkg::SLOT_W-1:0] slot;
    logic                        rv;
    logic [PID_W-1:0]            rpid;
    logic [PAGE_W-1:0]           rpage;
  } dir_resp_t;

  logic                         clk_i         = 1'b0;
  logic                         rst_ni        = 1'b0;
  logic [CMD_W-1:0]             s_axis_tdata  = '0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [RESP_W-1:0]            m_axis_tdata;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [pctr_pkg::LIMIT_W-1:0] cfg_data_i    = '0;
  logic                         cfg_valid_i   = 1'b0;
  logic                         cfg_ready_o;

  // predicted directory contents and quota
  logic [PID_W-1:0]             dir_pid  [N_ENTRIES] = '{default: '0};
  logic [PAGE_W-1:0]            dir_page [N_ENTRIES] = '{default: '0};
  logic [AGE_W-1:0]             dir_age  [N_ENTRIES] = '{default: '0};
  logic [pctr_pkg::LIMIT_W-1:0] quota = pctr_pkg::LIMIT_RESET;

  dir_cmd_t            cmd_q[$];
  dir_resp_t           resp_due_q[$];
  dir_cmd_t            cur_cmd;

  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned n_bad = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;
  int unsigned hold_left = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  bit          src_idle = 1'b0;
  bit          snk_idle = 1'b0;

  page_cache_tag_replacement u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_data_i    (cfg_data_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o)
  );

  always #5 clk_i = ~clk_i;

  // largest age wins, lowest index on a tie
  function automatic int oldest_entry(input logic [PID_W-1:0] owner, input bit any_owner);
    int best;
    logic [AGE_W-1:0] best_age;
    best = -1;
    best_age = '0;
    for (int i = 0; i < N_ENTRIES; i++) begin
      if (dir_pid[i] != '0 && (any_owner || dir_pid[i] == owner) &&
          (best < 0 || dir_age[i] > best_age)) begin
        best = i;
        best_age = dir_age[i];
      end
    end
    return best;
  endfunction

  function automatic dir_resp_t dir_access(input dir_cmd_t c);
    dir_resp_t r;
    int hit;
    int victim;
    int first_free;
    int owned;
    r = '{status: pctr_pkg::ST_DONE, slot: '0, rv: 1'b0, rpid: '0, rpage: '0};
    if (c.op == pctr_pkg::OP_FLUSH) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        dir_pid[i] = '0;
        dir_page[i] = '0;
        dir_age[i] = '0;
      end
    end else if (c.pid == '0) begin
      r.status = pctr_pkg::ST_REJECT;
    end else if (c.op == pctr_pkg::OP_RELEASE) begin
      for (int i = 0; i < N_ENTRIES; i++) begin
        if (dir_pid[i] == c.pid) begin
          dir_pid[i] = '0;
          dir_page[i] = '0;
          dir_age[i] = '0;
        end
      end
    end else begin
      // reads age every occupied entry before the lookup
      if (c.op == pctr_pkg::OP_READ) begin
        for (int i = 0; i < N_ENTRIES; i++)
          if (dir_pid[i] != '0 && dir_age[i] != '1) dir_age[i] = dir_age[i] + 1'b1;
      end
      hit = -1;
      for (int i = 0; i < N_ENTRIES; i++)
        if (hit < 0 && dir_pid[i] == c.pid && dir_page[i] == c.page) hit = i;
      if (hit >= 0) begin
        r.status = pctr_pkg::ST_HIT;
        r.slot = hit[pctr_pkg::SLOT_W-1:0];
        if (c.op == pctr_pkg::OP_WRITE) dir_age[hit] = '0;
      end else if (c.op == pctr_pkg::OP_WRITE) begin
        r.status = pctr_pkg::ST_WMISS;
      end else begin
        owned = 0;
        first_free = -1;
        for (int i = 0; i < N_ENTRIES; i++) begin
          if (dir_pid[i] == c.pid) owned++;
          if (dir_pid[i] == '0 && first_free < 0) first_free = i;
        end
        if (owned > 0 && owned >= int'(quota)) victim = oldest_entry(c.pid, 1'b0);
        else if (first_free >= 0) victim = first_free;
        else victim = oldest_entry('0, 1'b1);
        if (victim < 0) victim = 0;
        if (dir_pid[victim] != '0) begin
          r.rv = 1'b1;
          r.rpid = dir_pid[victim];
          r.rpage = dir_page[victim];
        end
        dir_pid[victim] = c.pid;
        dir_page[victim] = c.page;
        dir_age[victim] = '0;
        r.status = pctr_pkg::ST_FILLED;
        r.slot = victim[pctr_pkg::SLOT_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : cmd_driver
    bit accepted;
    bit free;
    int unsigned sent_now;
    dir_cmd_t nxt;
    accepted = s_axis_tvalid && s_axis_tready;
    free = !s_axis_tvalid || s_axis_tready;
    sent_now = n_sent + (accepted ? 1 : 0);
    if (rst_ni) begin
      if (accepted) begin
        resp_due_q.push_back(dir_access(cur_cmd));
        n_sent <= sent_now;
      end
      if (free) begin
        if (src_gap != 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (cmd_q.size() == 0 || (cmd_q[0].drain && sent_now != n_got)) begin
          // nothing queued, or this word waits until every result is back
          s_axis_tvalid <= 1'b0;
        end else if (src_idle && $urandom_range(0, 4) == 0) begin
          src_gap <= $urandom_range(0, 12);
          s_axis_tvalid <= 1'b0;
        end else begin
          nxt = cmd_q.pop_front();
          cur_cmd <= nxt;
          s_axis_tdata <= {{(CMD_W-pctr_pkg::OP_W-PID_W-PAGE_W){1'b0}},
                           nxt.page, nxt.pid, nxt.op};
          s_axis_tvalid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk_i) begin : sink_hold
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i) begin : resp_checker
    dir_resp_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_got <= n_got + 1;
        if (resp_due_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("%0t: unexpected result word %h", $time, m_axis_tdata);
        end else begin
          want = resp_due_q.pop_front();
          if (m_axis_tdata[2:0] !== want.status || m_axis_tdata[6:3] !== want.slot ||
              m_axis_tdata[7] !== want.rv || m_axis_tdata[23:8] !== want.rpid ||
              m_axis_tdata[39:24] !== want.rpage) begin
            n_bad++;
            if (n_bad <= 10)
              $display("%0t: status/slot/rv/rpid/rpage exp %0d/%0d/%0d/%h/%h got %0d/%0d/%0d/%h/%h",
                       $time, want.status, want.slot, want.rv, want.rpid, want.rpage,
                       m_axis_tdata[2:0], m_axis_tdata[6:3], m_axis_tdata[7],
                       m_axis_tdata[23:8], m_axis_tdata[39:24]);
          end
        end
      end
      if (snk_gap != 0) begin
        snk_gap <= snk_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else if (snk_idle && $urandom_range(0, 5) == 0) begin
        snk_gap <= $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic add_cmd(input pctr_pkg::op_e op, input logic [PID_W-1:0] pid,
                         input logic [PAGE_W-1:0] page, input bit drain);
    dir_cmd_t c;
    c.op = op;
    c.pid = pid;
    c.page = page;
    c.drain = drain;
    cmd_q.push_back(c);
  endtask

  task automatic wait_idle(input int unsigned extra);
    do @(negedge clk_i); while (cmd_q.size() != 0 || s_axis_tvalid || n_sent != n_got);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic write_quota(input logic [pctr_pkg::LIMIT_W-1:0] v);
    @(posedge clk_i);
    cfg_data_i <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    quota = v;
    cfg_valid_i <= 1'b0;
  endtask

  // small pools of pids and pages so hits, quota pressure and full directories occur
  task automatic random_phase(input int unsigned n_items);
    logic [PID_W-1:0]  pids [6];
    logic [PAGE_W-1:0] pages [16];
    int unsigned n_pids;
    int unsigned n_pages;
    int unsigned pick;
    pctr_pkg::op_e op;
    logic [PID_W-1:0] pid;
    logic [PAGE_W-1:0] page;
    n_pids = $urandom_range(1, 6);
    n_pages = $urandom_range(2, 16);
    foreach (pids[i]) pids[i] = PID_W'($urandom_range(1, 65535));
    foreach (pages[i]) pages[i] = PAGE_W'($urandom);
    for (int k = 0; k < n_items; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 64) op = pctr_pkg::OP_READ;
      else if (pick < 88) op = pctr_pkg::OP_WRITE;
      else if (pick < 97) op = pctr_pkg::OP_RELEASE;
      else op = pctr_pkg::OP_FLUSH;
      pid = pids[$urandom_range(0, n_pids - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 3) pid = '0;
      else if (pick < 10) pid = PID_W'($urandom);
      if ($urandom_range(0, 9) == 0) page = PAGE_W'($urandom);
      else page = pages[$urandom_range(0, n_pages - 1)];
      add_cmd(op, pid, page, k == n_items / 3);
    end
  endtask

  initial begin : run
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed words at the reset quota of two
    @(negedge clk_i);
    add_cmd(pctr_pkg::OP_READ, '0, 16'h1234, 1'b0);
    add_cmd(pctr_pkg::OP_WRITE, '0, '0, 1'b0);
    add_cmd(pctr_pkg::OP_RELEASE, '0, 16'hFFFF, 1'b0);
    add_cmd(pctr_pkg::OP_FLUSH, 16'hA5A5, 16'h5A5A, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'd1, '0, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'd1, '0, 1'b0);
    add_cmd(pctr_pkg::OP_WRITE, 16'd1, '0, 1'b0);
    add_cmd(pctr_pkg::OP_WRITE, 16'd1, 16'd5, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'd1, 16'hFFFF, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'd1, 16'd7, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'hFFFF, 16'hFFFF, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'hFFFF, '0, 1'b0);
    add_cmd(pctr_pkg::OP_RELEASE, 16'd3, '0, 1'b0);
    add_cmd(pctr_pkg::OP_RELEASE, 16'd1, '0, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'd2, 16'd9, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'hFFFF, 16'd1, 1'b0);
    add_cmd(pctr_pkg::OP_WRITE, 16'hFFFF, 16'd1, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'h8000, 16'h8000, 1'b0);
    add_cmd(pctr_pkg::OP_WRITE, 16'h8000, 16'h8000, 1'b0);
    add_cmd(pctr_pkg::OP_FLUSH, '0, '0, 1'b0);
    add_cmd(pctr_pkg::OP_READ, 16'h8000, 16'h8000, 1'b0);
    wait_idle(4);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 0) write_quota(5'd1);
      else if (ph == 1) write_quota(5'd16);
      else write_quota(pctr_pkg::LIMIT_W'($urandom_range(1, 16)));
      @(negedge clk_i);
      src_idle = (ph != N_PHASES - 1) && (ph % 3 != 2);
      snk_idle = (ph != N_PHASES - 1) && (ph % 3 != 1);
      // receiver holds off while the sender keeps offering
      if (ph == 2 || ph == 5) hold_req = hold_req + 1;
      random_phase(PHASE_ITEMS);
      wait_idle(4);
    end

    wait_idle(N_ENTRIES + 8);
    if (n_bad == 0 && resp_due_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
